// ===== design/asd_pkg.sv =====
// ----------------------------------------------------------------------------
// asd_pkg
// Shared types, register codes, reset values and the control store of the
// step detector sequencer.
// ----------------------------------------------------------------------------
package asd_pkg;

   localparam int SAMPLE_BITS_DEF = 12;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ALPHA   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY_LEVEL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_THRESHOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_STEP_MS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SAVE_MS        = 3'd5;

   localparam logic [8:0]  ALPHA_RST    = 9'd230;
   localparam logic [8:0]  ALPHA_FULL   = 9'd256;
   localparam logic [11:0] GRAVITY_RST  = 12'd1024;
   localparam logic [11:0] RISE_RST     = 12'd358;
   localparam logic [11:0] FALL_RST     = 12'd154;
   localparam logic [15:0] MIN_STEP_RST = 16'd250;
   localparam logic [15:0] SAVE_RST     = 16'd10000;

   // Filtered level range.
   localparam int FILT_W   = 13;
   localparam int FILT_MAX = 4095;
   localparam int FILT_MIN = -4096;

   typedef struct packed {
      logic [8:0]  filter_alpha;
      logic [11:0] gravity_level;
      logic [11:0] rise_threshold;
      logic [11:0] fall_threshold;
      logic [15:0] min_step_ms;
      logic [15:0] save_ms;
   } asd_cfg_type;

   // Operand pair feeding the shared multiplier.
   typedef enum logic [2:0] {
      MUL_NONE  = 3'd0,
      MUL_SQ_X  = 3'd1,
      MUL_SQ_Y  = 3'd2,
      MUL_SQ_Z  = 3'd3,
      MUL_F_OLD = 3'd4,
      MUL_F_LIN = 3'd5
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_LOAD = 2'd1,
      ACC_ADD  = 2'd2
   } acc_op_type;

   typedef enum logic [1:0] {
      SEQ_NEXT    = 2'd0,
      SEQ_WAIT_IN = 2'd1,
      SEQ_LOOP    = 2'd2,
      SEQ_EMIT    = 2'd3
   } seq_op_type;

   typedef logic [3:0] pc_type;

   localparam pc_type PC_IDLE    = 4'd0;
   localparam pc_type PC_SQ_X    = 4'd1;
   localparam pc_type PC_SQ_Y    = 4'd2;
   localparam pc_type PC_SQ_Z    = 4'd3;
   localparam pc_type PC_SQ_INIT = 4'd4;
   localparam pc_type PC_SQ_STEP = 4'd5;
   localparam pc_type PC_LIN     = 4'd6;
   localparam pc_type PC_F_OLD   = 4'd7;
   localparam pc_type PC_F_LIN   = 4'd8;
   localparam pc_type PC_FILT    = 4'd9;
   localparam pc_type PC_DECIDE  = 4'd10;
   localparam pc_type PC_EMIT    = 4'd11;

   typedef struct packed {
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        sqrt_init;
      logic        sqrt_step;
      logic        lin_load;
      logic        filt_load;
      logic        decide;
      logic        loop_load;
      seq_op_type  seq;
      pc_type      target;
   } asd_uword_type;

   // Datapath strobes issued by the sequencer for the current cycle.
   typedef struct packed {
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        sqrt_init;
      logic        sqrt_step;
      logic        lin_load;
      logic        filt_load;
      logic        decide;
      logic        capture;
      logic        emit;
   } asd_ctrl_type;

   localparam asd_uword_type UWORD_NOP = '{
      mul_sel:   MUL_NONE,
      acc_op:    ACC_HOLD,
      sqrt_init: 1'b0,
      sqrt_step: 1'b0,
      lin_load:  1'b0,
      filt_load: 1'b0,
      decide:    1'b0,
      loop_load: 1'b0,
      seq:       SEQ_NEXT,
      target:    PC_IDLE
   };

   // Control store: one word per step.
   function automatic asd_uword_type ucode_word(input pc_type pc);
      asd_uword_type w;
      w = UWORD_NOP;
      unique case (pc)
         PC_IDLE: begin
            w.seq = SEQ_WAIT_IN;
         end
         PC_SQ_X: begin
            w.mul_sel = MUL_SQ_X;
            w.acc_op  = ACC_LOAD;
         end
         PC_SQ_Y: begin
            w.mul_sel = MUL_SQ_Y;
            w.acc_op  = ACC_ADD;
         end
         PC_SQ_Z: begin
            w.mul_sel = MUL_SQ_Z;
            w.acc_op  = ACC_ADD;
         end
         PC_SQ_INIT: begin
            w.sqrt_init = 1'b1;
            w.loop_load = 1'b1;
         end
         PC_SQ_STEP: begin
            w.sqrt_step = 1'b1;
            w.seq       = SEQ_LOOP;
            w.target    = PC_SQ_STEP;
         end
         PC_LIN: begin
            w.lin_load = 1'b1;
         end
         PC_F_OLD: begin
            w.mul_sel = MUL_F_OLD;
            w.acc_op  = ACC_LOAD;
         end
         PC_F_LIN: begin
            w.mul_sel = MUL_F_LIN;
            w.acc_op  = ACC_ADD;
         end
         PC_FILT: begin
            w.filt_load = 1'b1;
         end
         PC_DECIDE: begin
            w.decide = 1'b1;
         end
         PC_EMIT: begin
            w.seq    = SEQ_EMIT;
            w.target = PC_IDLE;
         end
         default: begin
            w.target = PC_IDLE;
            w.seq    = SEQ_EMIT;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== design/asd_if.sv =====
// ----------------------------------------------------------------------------
// asd_if
// Valid/ready channels of the step detector: samples, results, register writes.
// ----------------------------------------------------------------------------
interface asd_req_if #(
   parameter int SAMPLE_BITS = asd_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] accel_x;
   logic signed [SAMPLE_BITS-1:0] accel_y;
   logic signed [SAMPLE_BITS-1:0] accel_z;
   logic [31:0]                   time_ms;

   modport source (output valid, accel_x, accel_y, accel_z, time_ms, input ready);
   modport sink   (input valid, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

interface asd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [31:0]                       step_count;
   logic                              step_detected;
   logic                              save_request;
   logic signed [asd_pkg::FILT_W-1:0] filtered_level;

   modport source (output valid, step_count, step_detected, save_request, filtered_level,
                   input ready);
   modport sink   (input valid, step_count, step_detected, save_request, filtered_level,
                   output ready);
endinterface

interface asd_csr_if;
   logic                             valid;
   logic                             ready;
   logic [asd_pkg::CSR_IDX_W-1:0]    index;
   logic [asd_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/accel_step_detector_core.sv =====
// ----------------------------------------------------------------------------
// accel_step_detector_core
// Threshold step counter on a three-axis accelerometer, run by a microcoded
// sequencer over one shared multiplier and a bit-pair square root unit.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Handshake      Carries
//   req_chan   in         valid/ready    accel_x, accel_y, accel_z, time_ms
//   rsp_chan   out        valid/ready    step_count, step_detected,
//                                        save_request, filtered_level
//   csr_chan   in         valid/ready    index, data (register write)
//
// A result is loaded once the squares, the square root loop, gravity removal, the
// filter and the step decisions are done, and the next item is taken only after
// that load; the square root loop, one root bit per cycle, sets most of that time.
// Synchronous active-high reset clears the sequencer, detector state and result valid flag.
// The sequencer stalls on its result step only while the output register holds a
// result that is not being taken; register writes are always accepted.
// ----------------------------------------------------------------------------
module accel_step_detector_core #(
   parameter int SAMPLE_BITS = asd_pkg::SAMPLE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   asd_req_if.sink   req_chan,
   asd_rsp_if.source rsp_chan,
   asd_csr_if.sink   csr_chan
);

   asd_pkg::asd_ctrl_type ctrl;
   asd_pkg::asd_cfg_type  cfg;
   logic                  out_busy;
   logic                  req_ready;

   assign req_chan.ready = req_ready;

   // Register file.
   asd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_chan.valid),
      .wr_ready (csr_chan.ready),
      .wr_index (csr_chan.index),
      .wr_data  (csr_chan.data),
      .cfg      (cfg)
   );

   // The sequencer steps through the control store: capture, three squares
   // into the accumulator, the root loop, gravity removal, the two filter
   // products, saturation, the step decisions and finally the result load.
   asd_sequencer #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .out_busy  (out_busy),
      .ctrl      (ctrl)
   );

   asd_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .cfg            (cfg),
      .accel_x        (req_chan.accel_x),
      .accel_y        (req_chan.accel_y),
      .accel_z        (req_chan.accel_z),
      .time_ms        (req_chan.time_ms),
      .rsp_ready      (rsp_chan.ready),
      .out_busy       (out_busy),
      .rsp_valid      (rsp_chan.valid),
      .step_count     (rsp_chan.step_count),
      .step_detected  (rsp_chan.step_detected),
      .save_request   (rsp_chan.save_request),
      .filtered_level (rsp_chan.filtered_level)
   );

`ifndef NO_ASSERTIONS
   // Once an item is taken the sequencer is busy on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_ready) |=> !req_ready)
      else $error("input ready stayed high after an item was accepted");

   // A result is never loaded over one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> !(rsp_chan.valid && !rsp_chan.ready))
      else $error("result register overwritten while still pending");

   // Results are only loaded while no new item is being captured.
   a_emit_not_capture: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.emit && ctrl.capture))
      else $error("capture and result load in the same cycle");
`endif

endmodule

// ===== design/asd_csr.sv =====
// ----------------------------------------------------------------------------
// asd_csr
// Configuration registers, written through the register write channel.
// ----------------------------------------------------------------------------
module asd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_valid,
   output logic                            wr_ready,
   input  logic [asd_pkg::CSR_IDX_W-1:0]   wr_index,
   input  logic [asd_pkg::CSR_DATA_W-1:0]  wr_data,
   output asd_pkg::asd_cfg_type            cfg
);

   asd_pkg::asd_cfg_type cfg_ff, cfg_in;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         unique case (wr_index)
            asd_pkg::CSR_FILTER_ALPHA:   cfg_in.filter_alpha   = wr_data[8:0];
            asd_pkg::CSR_GRAVITY_LEVEL:  cfg_in.gravity_level  = wr_data[11:0];
            asd_pkg::CSR_RISE_THRESHOLD: cfg_in.rise_threshold = wr_data[11:0];
            asd_pkg::CSR_FALL_THRESHOLD: cfg_in.fall_threshold = wr_data[11:0];
            asd_pkg::CSR_MIN_STEP_MS:    cfg_in.min_step_ms    = wr_data;
            asd_pkg::CSR_SAVE_MS:        cfg_in.save_ms        = wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_alpha   <= asd_pkg::ALPHA_RST;
         cfg_ff.gravity_level  <= asd_pkg::GRAVITY_RST;
         cfg_ff.rise_threshold <= asd_pkg::RISE_RST;
         cfg_ff.fall_threshold <= asd_pkg::FALL_RST;
         cfg_ff.min_step_ms    <= asd_pkg::MIN_STEP_RST;
         cfg_ff.save_ms        <= asd_pkg::SAVE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/asd_sequencer.sv =====
// ----------------------------------------------------------------------------
// asd_sequencer
// Step counter, loop counter and control store of the microcoded sequencer.
// ----------------------------------------------------------------------------
module asd_sequencer #(
   parameter int SAMPLE_BITS = asd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  out_busy,
   output asd_pkg::asd_ctrl_type ctrl
);

   localparam int LOOP_W = $clog2(SAMPLE_BITS + 1);

   asd_pkg::pc_type        pc_ff, pc_in;
   logic [LOOP_W-1:0]      loop_ff, loop_in;
   asd_pkg::asd_uword_type word;

   assign word      = asd_pkg::ucode_word(pc_ff);
   assign req_ready = (word.seq == asd_pkg::SEQ_WAIT_IN);

   always_comb begin
      pc_in          = pc_ff;
      loop_in        = loop_ff;
      ctrl.mul_sel   = word.mul_sel;
      ctrl.acc_op    = word.acc_op;
      ctrl.sqrt_init = word.sqrt_init;
      ctrl.sqrt_step = word.sqrt_step;
      ctrl.lin_load  = word.lin_load;
      ctrl.filt_load = word.filt_load;
      ctrl.decide    = word.decide;
      ctrl.capture   = 1'b0;
      ctrl.emit      = 1'b0;
      if (word.loop_load) begin
         loop_in = LOOP_W'(SAMPLE_BITS);
      end
      case (word.seq)
         asd_pkg::SEQ_NEXT: begin
            pc_in = pc_ff + 4'd1;
         end
         asd_pkg::SEQ_WAIT_IN: begin
            if (req_valid) begin
               ctrl.capture = 1'b1;
               pc_in        = pc_ff + 4'd1;
            end
         end
         asd_pkg::SEQ_LOOP: begin
            loop_in = loop_ff - LOOP_W'(1);
            if (loop_ff != LOOP_W'(1)) begin
               pc_in = word.target;
            end else begin
               pc_in = pc_ff + 4'd1;
            end
         end
         asd_pkg::SEQ_EMIT: begin
            if (!out_busy) begin
               ctrl.emit = 1'b1;
               pc_in     = word.target;
            end
         end
         default: begin
            pc_in = asd_pkg::PC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= asd_pkg::PC_IDLE;
         loop_ff <= '0;
      end else begin
         pc_ff   <= pc_in;
         loop_ff <= loop_in;
      end
   end

endmodule

// ===== design/asd_datapath.sv =====
// ----------------------------------------------------------------------------
// asd_datapath
// Shared multiplier and accumulator, digit-by-digit square root, low-pass
// filter, step and save decisions, and the result register.
// ----------------------------------------------------------------------------
module asd_datapath #(
   parameter int SAMPLE_BITS = asd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  asd_pkg::asd_ctrl_type              ctrl,
   input  asd_pkg::asd_cfg_type               cfg,
   input  logic signed [SAMPLE_BITS-1:0]      accel_x,
   input  logic signed [SAMPLE_BITS-1:0]      accel_y,
   input  logic signed [SAMPLE_BITS-1:0]      accel_z,
   input  logic [31:0]                        time_ms,
   input  logic                               rsp_ready,
   output logic                               out_busy,
   output logic                               rsp_valid,
   output logic [31:0]                        step_count,
   output logic                               step_detected,
   output logic                               save_request,
   output logic signed [asd_pkg::FILT_W-1:0]  filtered_level
);

   localparam int SQ_W  = 2 * SAMPLE_BITS;
   localparam int REM_W = SAMPLE_BITS + 2;
   localparam int LIN_W = ((SAMPLE_BITS > 12) ? SAMPLE_BITS : 12) + 2;
   localparam int MUL_W = LIN_W;
   localparam int ACC_W = 2 * MUL_W;
   localparam int FW    = asd_pkg::FILT_W;

   localparam logic signed [ACC_W-1:0] F_MAX = ACC_W'(asd_pkg::FILT_MAX);
   localparam logic signed [ACC_W-1:0] F_MIN = ACC_W'(asd_pkg::FILT_MIN);

   // Captured sample.
   logic signed [SAMPLE_BITS-1:0] x_ff, y_ff, z_ff;
   logic [31:0]                   now_ff;

   // Arithmetic registers.
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic [SQ_W-1:0]               rad_ff, rad_in;
   logic [REM_W-1:0]              rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0]        root_ff, root_in;
   logic signed [LIN_W-1:0]       lin_ff;

   // Detector state.
   logic signed [FW-1:0]          filter_ff, filter_in;
   logic                          armed_ff, armed_in;
   logic [31:0]                   count_ff, count_in;
   logic [31:0]                   last_step_ff, last_step_in;
   logic [31:0]                   last_save_ff, last_save_in;
   logic                          det_ff, det_in;
   logic                          save_ff, save_in;

   // Result register.
   logic                          rsp_valid_ff;
   logic [31:0]                   rsp_count_ff;
   logic                          rsp_det_ff;
   logic                          rsp_save_ff;
   logic signed [FW-1:0]          rsp_level_ff;

   logic [8:0]                    alpha_sat;
   logic [8:0]                    beta;
   logic signed [MUL_W-1:0]       op_a, op_b;
   logic signed [ACC_W-1:0]       product;
   logic signed [ACC_W-1:0]       shifted;
   logic [REM_W-1:0]              rem_sh, trial;
   logic signed [FW-1:0]          rise_s, fall_s;
   logic                          arm, armed_mid, fall_hit;
   logic [31:0]                   since_step, since_save;

   // Weights above one are clamped so the filter simply holds its value.
   assign alpha_sat = (cfg.filter_alpha > asd_pkg::ALPHA_FULL) ?
                      asd_pkg::ALPHA_FULL : cfg.filter_alpha;
   assign beta      = asd_pkg::ALPHA_FULL - alpha_sat;

   always_comb begin
      case (ctrl.mul_sel)
         asd_pkg::MUL_SQ_X: begin
            op_a = MUL_W'(x_ff);
            op_b = MUL_W'(x_ff);
         end
         asd_pkg::MUL_SQ_Y: begin
            op_a = MUL_W'(y_ff);
            op_b = MUL_W'(y_ff);
         end
         asd_pkg::MUL_SQ_Z: begin
            op_a = MUL_W'(z_ff);
            op_b = MUL_W'(z_ff);
         end
         asd_pkg::MUL_F_OLD: begin
            op_a = $signed({{(MUL_W-9){1'b0}}, alpha_sat});
            op_b = MUL_W'(filter_ff);
         end
         asd_pkg::MUL_F_LIN: begin
            op_a = $signed({{(MUL_W-9){1'b0}}, beta});
            op_b = lin_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign product = ACC_W'(op_a) * ACC_W'(op_b);

   always_comb begin
      case (ctrl.acc_op)
         asd_pkg::ACC_LOAD: acc_in = product;
         asd_pkg::ACC_ADD:  acc_in = acc_ff + product;
         default:           acc_in = acc_ff;
      endcase
   end

   // One root bit per step: bring down two radicand bits, try (root<<2)|1.
   assign rem_sh = {rem_ff[SAMPLE_BITS-1:0], rad_ff[SQ_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (ctrl.sqrt_init) begin
         rad_in  = acc_ff[SQ_W-1:0];
         rem_in  = '0;
         root_in = '0;
      end else if (ctrl.sqrt_step) begin
         rad_in = {rad_ff[SQ_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[SAMPLE_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[SAMPLE_BITS-2:0], 1'b0};
         end
      end
   end

   assign shifted = acc_ff >>> 8;

   always_comb begin
      filter_in = filter_ff;
      if (ctrl.filt_load) begin
         if (shifted > F_MAX) begin
            filter_in = F_MAX[FW-1:0];
         end else if (shifted < F_MIN) begin
            filter_in = F_MIN[FW-1:0];
         end else begin
            filter_in = shifted[FW-1:0];
         end
      end
   end

   // Arming is tested before counting, so one sample may do both.
   assign rise_s     = $signed({1'b0, cfg.rise_threshold});
   assign fall_s     = $signed({1'b0, cfg.fall_threshold});
   assign since_step = now_ff - last_step_ff;
   assign since_save = now_ff - last_save_ff;
   assign arm        = (filter_ff > rise_s) && !armed_ff &&
                       (since_step > {16'd0, cfg.min_step_ms});
   assign armed_mid  = armed_ff | arm;
   assign fall_hit   = (filter_ff < fall_s) && armed_mid;

   always_comb begin
      armed_in     = armed_ff;
      count_in     = count_ff;
      last_step_in = last_step_ff;
      last_save_in = last_save_ff;
      det_in       = det_ff;
      save_in      = save_ff;
      if (ctrl.decide) begin
         armed_in = armed_mid;
         det_in   = fall_hit;
         save_in  = (since_save >= {16'd0, cfg.save_ms});
         if (fall_hit) begin
            count_in     = count_ff + 32'd1;
            last_step_in = now_ff;
            armed_in     = 1'b0;
         end
         if (since_save >= {16'd0, cfg.save_ms}) begin
            last_save_in = now_ff;
         end
      end
   end

   assign out_busy = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         x_ff   <= accel_x;
         y_ff   <= accel_y;
         z_ff   <= accel_z;
         now_ff <= time_ms;
      end
      if (ctrl.lin_load) begin
         lin_ff <= $signed({{(LIN_W-SAMPLE_BITS){1'b0}}, root_ff}) -
                   $signed({{(LIN_W-12){1'b0}}, cfg.gravity_level});
      end
      if (ctrl.emit) begin
         rsp_count_ff <= count_ff;
         rsp_det_ff   <= det_ff;
         rsp_save_ff  <= save_ff;
         rsp_level_ff <= filter_ff;
      end
      acc_ff  <= acc_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      det_ff  <= det_in;
      save_ff <= save_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff    <= '0;
         armed_ff     <= 1'b0;
         count_ff     <= '0;
         last_step_ff <= '0;
         last_save_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         filter_ff    <= filter_in;
         armed_ff     <= armed_in;
         count_ff     <= count_in;
         last_step_ff <= last_step_in;
         last_save_ff <= last_save_in;
         if (ctrl.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign step_count     = rsp_count_ff;
   assign step_detected  = rsp_det_ff;
   assign save_request   = rsp_save_ff;
   assign filtered_level = rsp_level_ff;

endmodule

// ===== bench/asd_result_checker.sv =====
// ----------------------------------------------------------------------------
// asd_result_checker
// Watches the sample, result and register channels of the step detector. It
// keeps its own copy of the detector state and registers, predicts one result
// per accepted sample and compares each accepted result with the oldest
// prediction.
// ----------------------------------------------------------------------------
module asd_result_checker
   import asd_pkg::*;
#(
   parameter int SAMPLE_W = SAMPLE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] accel_x,
   input  logic signed [SAMPLE_W-1:0] accel_y,
   input  logic signed [SAMPLE_W-1:0] accel_z,
   input  logic [31:0]                time_ms,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [31:0]                step_count,
   input  logic                       step_detected,
   input  logic                       save_request,
   input  logic signed [FILT_W-1:0]   filtered_level,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   output int                         failures,
   output int                         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0]              step_count;
      logic                     step_detected;
      logic                     save_request;
      logic signed [FILT_W-1:0] filtered_level;
   } step_report_type;

   asd_cfg_type     regs;
   int              level_state;
   logic            armed;
   logic [31:0]     steps_total;
   logic [31:0]     last_step_ms;
   logic [31:0]     last_save_ms;
   step_report_type reports_due[$];
   int              fault_total = 0;
   int              results_seen = 0;

   // Advances the detector by one sample and returns the report it produces.
   function automatic step_report_type detect_step(
      input logic signed [SAMPLE_W-1:0] ax,
      input logic signed [SAMPLE_W-1:0] ay,
      input logic signed [SAMPLE_W-1:0] az,
      input logic [31:0]                now
   );
      longint          energy;
      logic [15:0]     root;
      logic [15:0]     trial;
      int              linear;
      int              weight;
      int              level;
      logic [31:0]     elapsed;
      step_report_type r;
      energy = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay) +
               longint'(az) * longint'(az);
      root = '0;
      for (int b = 15; b >= 0; b--) begin
         trial = root | (16'd1 << b);
         if (longint'(trial) * longint'(trial) <= energy) begin
            root = trial;
         end
      end
      linear = int'(root) - int'(regs.gravity_level);
      weight = (regs.filter_alpha > ALPHA_FULL) ? 256 : int'(regs.filter_alpha);
      level = (weight * level_state + (256 - weight) * linear) >>> 8;
      if (level > FILT_MAX) begin
         level = FILT_MAX;
      end
      if (level < FILT_MIN) begin
         level = FILT_MIN;
      end
      level_state = level;
      r = '0;
      elapsed = now - last_step_ms;
      if (level > int'(regs.rise_threshold) && !armed && elapsed > 32'(regs.min_step_ms)) begin
         armed = 1'b1;
      end
      if (level < int'(regs.fall_threshold) && armed) begin
         steps_total = steps_total + 32'd1;
         last_step_ms = now;
         armed = 1'b0;
         r.step_detected = 1'b1;
      end
      elapsed = now - last_save_ms;
      if (elapsed >= 32'(regs.save_ms)) begin
         r.save_request = 1'b1;
         last_save_ms = now;
      end
      r.step_count = steps_total;
      r.filtered_level = level[FILT_W-1:0];
      return r;
   endfunction

   task automatic note_fault(input string what, input longint want, input longint got);
      if (fault_total < 10) begin
         $display("%t result %0d: %s expected %0d, got %0d", $realtime, results_seen, what,
                  want, got);
      end
      fault_total++;
   endtask

   always @(posedge clock) begin
      step_report_type want;
      if (reset) begin
         regs = '{filter_alpha: ALPHA_RST, gravity_level: GRAVITY_RST,
                  rise_threshold: RISE_RST, fall_threshold: FALL_RST,
                  min_step_ms: MIN_STEP_RST, save_ms: SAVE_RST};
         level_state = 0;
         armed = 1'b0;
         steps_total = '0;
         last_step_ms = '0;
         last_save_ms = '0;
         reports_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FILTER_ALPHA:   regs.filter_alpha = csr_data[8:0];
               CSR_GRAVITY_LEVEL:  regs.gravity_level = csr_data[11:0];
               CSR_RISE_THRESHOLD: regs.rise_threshold = csr_data[11:0];
               CSR_FALL_THRESHOLD: regs.fall_threshold = csr_data[11:0];
               CSR_MIN_STEP_MS:    regs.min_step_ms = csr_data;
               CSR_SAVE_MS:        regs.save_ms = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (reports_due.size() == 0) begin
               note_fault("result with nothing pending, step_count", -1, step_count);
            end else begin
               want = reports_due.pop_front();
               if (step_count !== want.step_count) begin
                  note_fault("step_count", want.step_count, step_count);
               end
               if (step_detected !== want.step_detected) begin
                  note_fault("step_detected", want.step_detected, step_detected);
               end
               if (save_request !== want.save_request) begin
                  note_fault("save_request", want.save_request, save_request);
               end
               if (filtered_level !== want.filtered_level) begin
                  note_fault("filtered_level", want.filtered_level, filtered_level);
               end
            end
            results_seen++;
         end
         if (req_valid && req_ready) begin
            reports_due.push_back(detect_step(accel_x, accel_y, accel_z, time_ms));
         end
      end
      failures <= fault_total;
      outstanding <= reports_due.size();
   end

endmodule

// ===== bench/accel_step_detector_core_test.sv =====
// ----------------------------------------------------------------------------
// accel_step_detector_core_test
// Drives samples and register writes into the step detector while a checker
// beside it predicts every result. Directed samples cover the sample and
// timestamp extremes, then phases of random settings run walking-like bursts
// mixed with noise, with random idling on both sides and one long receiver
// hold-off.
// ----------------------------------------------------------------------------
module accel_step_detector_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import asd_pkg::*;

   localparam int SAMPLE_W     = SAMPLE_BITS_DEF;
   localparam int AXIS_MAX     = 2 ** (SAMPLE_W - 1) - 1;
   localparam int AXIS_MIN     = -(2 ** (SAMPLE_W - 1));
   localparam int LATENCY      = SAMPLE_W + 11;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_ITEMS = 1330;
   localparam int PHASES       = 8;
   localparam int IDLE_PERCENT = 23;
   localparam int HOLD_CYCLES  = 400;

   // Phases with a special purpose; the others use random typical settings.
   localparam int PHASE_FLOOR    = 1;
   localparam int PHASE_CEILING  = 2;
   localparam int PHASE_CALM     = 3;
   localparam int PHASE_PRESSURE = 5;

   // Register indexes past the end of the register list; writes must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic        clock;
   logic        reset;
   logic        calm;
   logic        hold_request;
   int          failures;
   int          outstanding;
   int          sent = 0;
   logic [31:0] stamp_ms;
   asd_cfg_type cfg_now;

   asd_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_chan ();
   asd_rsp_if                           rsp_chan ();
   asd_csr_if                           csr_chan ();

   accel_step_detector_core #(.SAMPLE_BITS(SAMPLE_W)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   asd_result_checker #(.SAMPLE_W(SAMPLE_W)) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .accel_x        (req_chan.accel_x),
      .accel_y        (req_chan.accel_y),
      .accel_z        (req_chan.accel_z),
      .time_ms        (req_chan.time_ms),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .step_count     (rsp_chan.step_count),
      .step_detected  (rsp_chan.step_detected),
      .save_request   (rsp_chan.save_request),
      .filtered_level (rsp_chan.filtered_level),
      .csr_valid      (csr_chan.valid),
      .csr_ready      (csr_chan.ready),
      .csr_index      (csr_chan.index),
      .csr_data       (csr_chan.data),
      .failures       (failures),
      .outstanding    (outstanding)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Offers one sample and returns at the edge where it is accepted. Random
   // idle cycles before the offer are skipped while the calm stretch runs.
   task automatic offer_sample(
      input logic signed [SAMPLE_W-1:0] ax,
      input logic signed [SAMPLE_W-1:0] ay,
      input logic signed [SAMPLE_W-1:0] az,
      input logic [31:0]                stamp
   );
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.accel_x <= ax;
      req_chan.accel_y <= ay;
      req_chan.accel_z <= az;
      req_chan.time_ms <= stamp;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      sent++;
   endtask

   // Leaves valid high so that back-to-back writes never lower and raise it in
   // one step; the caller drops it after the last write.
   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready) begin
         @(posedge clock);
      end
   endtask

   // Writes all six registers. Bits above each register's width carry junk,
   // which the block is expected to drop.
   task automatic load_config(input asd_cfg_type c);
      csr_put(CSR_FILTER_ALPHA, {7'($urandom), c.filter_alpha});
      csr_put(CSR_GRAVITY_LEVEL, {4'($urandom), c.gravity_level});
      csr_put(CSR_RISE_THRESHOLD, {4'($urandom), c.rise_threshold});
      csr_put(CSR_FALL_THRESHOLD, {4'($urandom), c.fall_threshold});
      csr_put(CSR_MIN_STEP_MS, c.min_step_ms);
      csr_put(CSR_SAVE_MS, c.save_ms);
      csr_chan.valid <= 1'b0;
      cfg_now = c;
   endtask

   // Stops offering and waits until every predicted result has come back. The
   // first edge lets the checker count an item accepted at the current edge.
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
   endtask

   // Gives one axis a random sign and a little jitter, clamped to the sample range.
   function automatic logic signed [SAMPLE_W-1:0] to_axis(input int v);
      int s;
      s = ($urandom_range(1) != 0) ? v : -v;
      s = s + int'($urandom_range(0, 40)) - 20;
      if (s > AXIS_MAX) begin
         s = AXIS_MAX;
      end
      if (s < AXIS_MIN) begin
         s = AXIS_MIN;
      end
      return s[SAMPLE_W-1:0];
   endfunction

   // Offers a sample whose vector length is close to mag. Lengths beyond one
   // axis are spread over two or three axes; the leading axis rotates.
   task automatic offer_level(input int mag);
      int                         m;
      int                         part;
      int                         turn;
      logic signed [SAMPLE_W-1:0] v[3];
      m = (mag < 0) ? 0 : ((mag > 3500) ? 3500 : mag);
      if (m <= 2000) begin
         part = m;
      end else if (m <= 2800) begin
         part = m * 181 / 256;
      end else begin
         part = m * 148 / 256;
      end
      turn = $urandom_range(2);
      v[turn] = to_axis(part);
      v[(turn + 1) % 3] = to_axis((m > 2000) ? part : 0);
      v[(turn + 2) % 3] = to_axis((m > 2800) ? part : 0);
      stamp_ms = stamp_ms + 32'($urandom_range(20, 60));
      offer_sample(v[0], v[1], v[2], stamp_ms);
   endtask

   // One stride: a few samples well above one g, then a few well below it, at
   // roughly the sample rate of a real sensor. This is what arms and counts.
   task automatic walk_one_step();
      int g;
      g = int'(cfg_now.gravity_level);
      repeat ($urandom_range(2, 6)) begin
         offer_level(g + int'($urandom_range(200, 1600)));
      end
      repeat ($urandom_range(2, 8)) begin
         offer_level(g - int'($urandom_range(100, 1100)));
      end
   endtask

   // Fully random sample; half the time the timestamp jumps anywhere.
   task automatic offer_noise();
      if ($urandom_range(1) != 0) begin
         stamp_ms = $urandom;
      end else begin
         stamp_ms = stamp_ms + 32'($urandom_range(0, 300));
      end
      offer_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom), stamp_ms);
   endtask

   // Settings for one random phase. Two phases pin every register to its
   // lowest or highest value; the rest stay in a range where walking counts.
   function automatic asd_cfg_type pick_config(input int phase);
      asd_cfg_type c;
      if ($urandom_range(9) == 0) begin
         c.filter_alpha = 9'($urandom_range(257, 511));
      end else begin
         c.filter_alpha = 9'($urandom_range(0, 256));
      end
      c.gravity_level  = 12'($urandom_range(700, 1400));
      c.rise_threshold = 12'($urandom_range(50, 800));
      c.fall_threshold = 12'($urandom_range(0, 900));
      c.min_step_ms    = 16'($urandom_range(0, 700));
      c.save_ms        = 16'($urandom_range(0, 4000));
      if (phase == PHASE_FLOOR) begin
         c = '0;
      end else if (phase == PHASE_CEILING) begin
         c = '1;
      end
      return c;
   endfunction

   // Stops the run if the block hangs.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Result side: random back-pressure, none during the calm stretch, and a
   // single long hold-off when the stimulus asks for it. During the hold-off
   // the sender keeps offering, so the output register and then the
   // sequencer fill and the input channel stalls.
   initial begin : receiver
      bit held;
      held = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) begin
               @(posedge clock);
            end
         end else begin
            rsp_chan.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      asd_cfg_type c;
      int          quota;
      reset            = 1'b1;
      calm             = 1'b0;
      hold_request     = 1'b0;
      req_chan.valid   = 1'b0;
      req_chan.accel_x = '0;
      req_chan.accel_y = '0;
      req_chan.accel_z = '0;
      req_chan.time_ms = '0;
      csr_chan.valid   = 1'b0;
      csr_chan.index   = '0;
      csr_chan.data    = '0;
      cfg_now = '{filter_alpha: ALPHA_RST, gravity_level: GRAVITY_RST,
                  rise_threshold: RISE_RST, fall_threshold: FALL_RST,
                  min_step_ms: MIN_STEP_RST, save_ms: SAVE_RST};
      repeat (5) begin
         @(posedge clock);
      end
      reset <= 1'b0;

      // Writes to indexes past the register list must leave the defaults alone.
      csr_put(CSR_SPARE_LO, 16'hFFFF);
      csr_put(CSR_SPARE_HI, 16'h5A5A);
      csr_chan.valid <= 1'b0;

      // Default settings. A still sensor, then the largest vectors in four sign
      // patterns drive the level up and arm; free fall then counts a step.
      offer_sample(0, 0, 0, 32'd1000);
      offer_sample(-2048, -2048, -2048, 32'd1040);
      offer_sample(2047, 2047, 2047, 32'd1080);
      offer_sample(-2048, 2047, -2048, 32'd1120);
      offer_sample(2047, -2048, 2047, 32'd1160);
      stamp_ms = 32'd1160;
      repeat (6) begin
         stamp_ms = stamp_ms + 32'd40;
         offer_sample(0, 0, 0, stamp_ms);
      end
      // Single-axis extremes.
      offer_sample(2047, 0, 0, stamp_ms + 32'd40);
      offer_sample(-2048, 0, 0, stamp_ms + 32'd80);
      offer_sample(0, 2047, 0, stamp_ms + 32'd120);
      offer_sample(0, -2048, 0, stamp_ms + 32'd160);
      offer_sample(0, 0, 2047, stamp_ms + 32'd200);
      offer_sample(0, 0, -2048, stamp_ms + 32'd240);
      // Timestamp wrap: the first sample is long after the last save, the
      // second sits just past zero and must see only a short gap.
      offer_sample(0, 0, 1024, 32'hFFFF_FFF0);
      offer_sample(0, 0, 1024, 32'h0000_0010);

      // Rise threshold below the fall threshold with no filtering, no rearm
      // hold-off and a save on every sample: one sample arms and counts.
      settle();
      c = cfg_now;
      c.filter_alpha   = 9'd0;
      c.rise_threshold = 12'd100;
      c.fall_threshold = 12'd500;
      c.min_step_ms    = '0;
      c.save_ms        = '0;
      load_config(c);
      offer_sample(1324, 0, 0, 32'd100);
      offer_sample(0, 0, 1024, 32'd100);
      offer_sample(0, -1324, 0, 32'd101);

      // A weight above full scale freezes the filter.
      settle();
      c.filter_alpha = 9'd300;
      load_config(c);
      offer_sample(2047, 2047, 0, 32'd140);
      offer_sample(0, 0, 0, 32'd180);

      // Random phases, each with fresh settings and a fresh timestamp base.
      for (int p = 0; p < PHASES; p++) begin
         settle();
         load_config(pick_config(p));
         stamp_ms = $urandom;
         calm <= (p == PHASE_CALM);
         if (p == PHASE_PRESSURE) begin
            hold_request <= 1'b1;
         end
         quota = sent + RANDOM_ITEMS / PHASES;
         while (sent < quota) begin
            if ($urandom_range(99) < 80) begin
               walk_one_step();
            end else begin
               offer_noise();
            end
         end
      end

      settle();
      repeat (4 * LATENCY) begin
         @(posedge clock);
      end
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
